// File: hw/rtl/pidaw_pkg.sv
// shared types, register indexes and fixed-point helpers for the pid core
package pidaw_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned LimWidth   = 31;
   localparam int unsigned AddrWidth  = 3;
   localparam int unsigned WideWidth  = 48;
   localparam int unsigned DivSteps   = 48;
   localparam int unsigned CountWidth = 6;

   localparam logic [LimWidth-1:0] StepTimeReset = 31'd65536;

   // register indexes on the csr port
   localparam logic [AddrWidth-1:0] RegGainP      = 3'd0;
   localparam logic [AddrWidth-1:0] RegGainI      = 3'd1;
   localparam logic [AddrWidth-1:0] RegGainD      = 3'd2;
   localparam logic [AddrWidth-1:0] RegOutLimit   = 3'd3;
   localparam logic [AddrWidth-1:0] RegStepTime   = 3'd4;
   localparam logic [AddrWidth-1:0] RegIntLimit   = 3'd5;
   localparam logic [AddrWidth-1:0] RegGuardOn    = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P_MUL,
      ST_P_SCL,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_FIX,
      ST_D_MUL,
      ST_D_SCL,
      ST_E_MUL,
      ST_E_SCL,
      ST_CAND,
      ST_IC_MUL,
      ST_IC_SCL,
      ST_GUARD,
      ST_IO_MUL,
      ST_IO_SCL,
      ST_OUT
   } state_type;

   localparam logic signed [WideWidth-1:0] SatMax = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WideWidth-1:0] SatMin = -48'sh0000_8000_0000;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [WideWidth-1:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > SatMax) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SatMin) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DataWidth-1:0];
      end
      return r;
   endfunction

   // q16.16 rescale of a 64-bit product, truncating toward zero, saturated
   function automatic logic signed [DataWidth-1:0] qscale(input logic signed [63:0] p);
      logic signed [WideWidth-1:0] sh;
      sh = p[63:16];
      if (p[63] && (p[15:0] != 16'd0)) begin
         sh = sh + 48'sd1;
      end
      return sat32(sh);
   endfunction

endpackage

// File: hw/rtl/pid_controller_antiwindup_core.sv
// pid controller with conditional-integration anti-windup, signed q16.16
// the drive word is registered in ST_OUT after the p, d and integral steps,
//   later while the previous drive word still waits on rsp_tready
// req is taken only in ST_IDLE; one shared 32x32 multiplier is used five times
//   and a 48-step restoring divider forms the derivative
// reset: synchronous active-high; gains, limits and guard clear, step time
//   returns to 1.0, previous error and integral clear, no output pending
module pid_controller_antiwindup_core
   import pidaw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] setpoint, [63:32] measured
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] drive
   // register write port
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [AddrWidth-1:0] csr_addr,
   input  logic [31:0]          csr_wdata
);

   // configuration registers
   logic signed [DataWidth-1:0] gain_p_ff, gain_p_in;
   logic signed [DataWidth-1:0] gain_i_ff, gain_i_in;
   logic signed [DataWidth-1:0] gain_d_ff, gain_d_in;
   logic [LimWidth-1:0]         out_lim_ff, out_lim_in;
   logic [LimWidth-1:0]         step_ff, step_in;
   logic [LimWidth-1:0]         int_lim_ff, int_lim_in;
   logic                        guard_ff, guard_in;

   // controller state
   logic signed [DataWidth-1:0] prev_err_ff, prev_err_in;
   logic signed [DataWidth-1:0] integral_ff, integral_in;

   // sequencer and working registers
   state_type                   state_ff, state_in;
   logic signed [DataWidth-1:0] err_ff, err_in;
   logic signed [DataWidth-1:0] p_term_ff, p_term_in;
   logic signed [DataWidth-1:0] d_term_ff, d_term_in;
   logic signed [DataWidth-1:0] acc_ff, acc_in;     // deriv, err*dt, i-terms
   logic signed [DataWidth-1:0] cand_ff, cand_in;
   logic signed [63:0]          prod_ff, prod_in;
   logic [WideWidth-1:0]        quo_ff, quo_in;
   logic [LimWidth-1:0]         rem_ff, rem_in;
   logic [CountWidth-1:0]       cnt_ff, cnt_in;
   logic                        neg_ff, neg_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]        rsp_data_ff, rsp_data_in;

   // shared multiplier operands
   logic signed [DataWidth-1:0] mul_a, mul_b;

   // scratch values
   logic signed [DataWidth:0]   diff_wide;
   logic signed [DataWidth-1:0] diff_sat;
   logic signed [DataWidth-1:0] scaled;
   logic [DataWidth-1:0]        trial;
   logic                        trial_ge;
   logic signed [DataWidth:0]   sum_wide;
   logic signed [DataWidth-1:0] sum_sat;
   logic signed [DataWidth:0]   ilim_wide;
   logic signed [33:0]          u_sum;
   logic signed [33:0]          olim_wide;
   logic                        deepen;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign scaled    = qscale(prod_ff);
   assign olim_wide = {3'b000, out_lim_ff};
   assign ilim_wide = {2'b00, int_lim_ff};
   assign u_sum     = {{2{p_term_ff[31]}}, p_term_ff} + {{2{acc_ff[31]}}, acc_ff}
                    + {{2{d_term_ff[31]}}, d_term_ff};

   // divider step: bring next dividend bit into the remainder
   assign trial    = {rem_ff, quo_ff[WideWidth-1]};
   assign trial_ge = (trial >= {1'b0, step_ff});

   always_comb begin
      state_in     = state_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      out_lim_in   = out_lim_ff;
      step_in      = step_ff;
      int_lim_in   = int_lim_ff;
      guard_in     = guard_ff;
      prev_err_in  = prev_err_ff;
      integral_in  = integral_ff;
      err_in       = err_ff;
      p_term_in    = p_term_ff;
      d_term_in    = d_term_ff;
      acc_in       = acc_ff;
      cand_in      = cand_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      diff_wide    = '0;
      diff_sat     = '0;
      sum_wide     = '0;
      sum_sat      = '0;
      deepen       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes, taken only while idle by contract; the block itself does not enforce this
      if (csr_valid) begin
         unique case (csr_addr)
            RegGainP:    gain_p_in  = csr_wdata;
            RegGainI:    gain_i_in  = csr_wdata;
            RegGainD:    gain_d_in  = csr_wdata;
            RegOutLimit: out_lim_in = csr_wdata[LimWidth-1:0];
            RegStepTime: begin
               // zero step time would divide by zero, so it is dropped
               if (csr_wdata[LimWidth-1:0] != '0) begin
                  step_in = csr_wdata[LimWidth-1:0];
               end
            end
            RegIntLimit: int_lim_in = csr_wdata[LimWidth-1:0];
            RegGuardOn:  guard_in   = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               diff_wide = {req_tdata[31], req_tdata[31:0]} - {req_tdata[63], req_tdata[63:32]};
               err_in    = sat32({{15{diff_wide[32]}}, diff_wide});
               state_in  = ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            mul_a    = gain_p_ff;
            mul_b    = err_ff;
            state_in = ST_P_SCL;
         end
         ST_P_SCL: begin
            p_term_in = scaled;
            state_in  = ST_DIV_SETUP;
         end
         ST_DIV_SETUP: begin
            // error difference, then magnitude shifted up 16 for the quotient
            diff_wide   = {err_ff[31], err_ff} - {prev_err_ff[31], prev_err_ff};
            diff_sat    = sat32({{15{diff_wide[32]}}, diff_wide});
            neg_in      = diff_sat[31];
            quo_in      = {(diff_sat[31] ? (32'd0 - diff_sat) : diff_sat), 16'd0};
            rem_in      = '0;
            cnt_in      = '0;
            prev_err_in = err_ff;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? LimWidth'(trial - {1'b0, step_ff}) : trial[LimWidth-1:0];
            quo_in = {quo_ff[WideWidth-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(DivSteps - 1)) begin
               state_in = ST_DIV_FIX;
            end
         end
         ST_DIV_FIX: begin
            // apply sign and saturate the quotient magnitude
            if (neg_ff) begin
               if (quo_ff > 48'h0000_8000_0000) begin
                  acc_in = 32'sh8000_0000;
               end else begin
                  acc_in = 32'd0 - quo_ff[31:0];
               end
            end else begin
               if (quo_ff > 48'h0000_7FFF_FFFF) begin
                  acc_in = 32'sh7FFF_FFFF;
               end else begin
                  acc_in = quo_ff[31:0];
               end
            end
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_a    = gain_d_ff;
            mul_b    = acc_ff;
            state_in = ST_D_SCL;
         end
         ST_D_SCL: begin
            d_term_in = scaled;
            state_in  = ST_E_MUL;
         end
         ST_E_MUL: begin
            mul_a    = err_ff;
            mul_b    = {1'b0, step_ff};
            state_in = ST_E_SCL;
         end
         ST_E_SCL: begin
            acc_in   = scaled;
            state_in = ST_CAND;
         end
         ST_CAND: begin
            // integral candidate with optional symmetric clamp
            sum_wide = {integral_ff[31], integral_ff} + {acc_ff[31], acc_ff};
            sum_sat  = sat32({{15{sum_wide[32]}}, sum_wide});
            cand_in  = sum_sat;
            if (int_lim_ff != '0) begin
               if ($signed({sum_sat[31], sum_sat}) > ilim_wide) begin
                  cand_in = {1'b0, int_lim_ff};
               end else if ($signed({sum_sat[31], sum_sat}) < -ilim_wide) begin
                  cand_in = 32'd0 - {1'b0, int_lim_ff};
               end
            end
            state_in = ST_IC_MUL;
         end
         ST_IC_MUL: begin
            mul_a    = gain_i_ff;
            mul_b    = cand_ff;
            state_in = ST_IC_SCL;
         end
         ST_IC_SCL: begin
            acc_in   = scaled;
            state_in = ST_GUARD;
         end
         ST_GUARD: begin
            // with the guard on, freeze the integral when the candidate drive pushes further out
            deepen = ((u_sum > olim_wide) && !err_ff[31] && (err_ff != '0))
                  || ((u_sum < -olim_wide) && err_ff[31]);
            if (!guard_ff || !deepen) begin
               integral_in = cand_ff;
            end
            state_in = ST_IO_MUL;
         end
         ST_IO_MUL: begin
            mul_a    = gain_i_ff;
            mul_b    = integral_ff;
            state_in = ST_IO_SCL;
         end
         ST_IO_SCL: begin
            acc_in   = scaled;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (u_sum > olim_wide) begin
                  rsp_data_in = {1'b0, out_lim_ff};
               end else if (u_sum < -olim_wide) begin
                  rsp_data_in = 32'd0 - {1'b0, out_lim_ff};
               end else begin
                  rsp_data_in = u_sum[31:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      prod_in = mul_a * mul_b;
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_lim_ff   <= '0;
         step_ff      <= StepTimeReset;
         int_lim_ff   <= '0;
         guard_ff     <= 1'b0;
         prev_err_ff  <= '0;
         integral_ff  <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         out_lim_ff   <= out_lim_in;
         step_ff      <= step_in;
         int_lim_ff   <= int_lim_in;
         guard_ff     <= guard_in;
         prev_err_ff  <= prev_err_in;
         integral_ff  <= integral_in;
         cnt_ff       <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      p_term_ff   <= p_term_in;
      d_term_ff   <= d_term_in;
      acc_ff      <= acc_in;
      cand_ff     <= cand_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
